@@ sv/framed_packet_receiver_core_macros.svh @@
// Assertion helpers shared by the receiver core.
`ifndef FRAMED_PACKET_RECEIVER_CORE_MACROS_SVH
`define FRAMED_PACKET_RECEIVER_CORE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define FPRC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset.
`define FPRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/fprc_pkg.sv @@
`default_nettype none

package fprc_pkg;

   localparam int LEN_W = 7;

   localparam logic [1:0] KIND_FRAME    = 2'd0;
   localparam logic [1:0] KIND_ERROR    = 2'd1;
   localparam logic [1:0] KIND_OVERFLOW = 2'd2;

   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   localparam logic [7:0] CHAR_U     = 8'h55;
   localparam logic [7:0] CHAR_N     = 8'h4e;
   localparam logic [7:0] CHAR_E     = 8'h45;
   localparam logic [7:0] CHAR_R     = 8'h52;
   localparam logic [7:0] CHAR_COLON = 8'h3a;
   localparam logic [7:0] CSUM_SEED  = CHAR_U ^ CHAR_N ^ CHAR_E ^ CHAR_R ^ CHAR_COLON;

   localparam logic [7:0] TIMEOUT_RESET = 8'd6;

   // Frame completion handed from the parser to the readout.
   typedef struct packed {
      logic             valid;
      logic [1:0]       kind;
      logic [LEN_W-1:0] len;
      logic [7:0]       value;
      logic [7:0]       rchk;
   } fprc_event_type;

endpackage

`default_nettype wire

@@ sv/fprc_store.sv @@
`default_nettype none

module fprc_store #(
   parameter int STORE_DEPTH = 64,
   parameter int AW = 6
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [7:0]    wdata,
   input  wire logic          re,
   input  wire logic [AW-1:0] raddr,
   output logic [7:0]         rdata
);

   logic [7:0] mem [STORE_DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Read data holds until the next read.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

@@ sv/fprc_parser.sv @@
`default_nettype none

module fprc_parser #(
   parameter int STORE_DEPTH = 64,
   parameter int AW = 6
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    take,
   input  wire logic                    req_type,
   input  wire logic [7:0]              rx_byte,
   input  wire logic                    csr_we,
   input  wire logic [7:0]              csr_wdata,
   output logic                         st_we,
   output logic [AW-1:0]                st_waddr,
   output logic [7:0]                   st_wdata,
   output fprc_pkg::fprc_event_type     ev
);
   import fprc_pkg::*;

   localparam logic [2:0] ST_HUNT    = 3'd0;
   localparam logic [2:0] ST_H1      = 3'd1;
   localparam logic [2:0] ST_H2      = 3'd2;
   localparam logic [2:0] ST_H3      = 3'd3;
   localparam logic [2:0] ST_LEN     = 3'd4;
   localparam logic [2:0] ST_TOKEN   = 3'd5;
   localparam logic [2:0] ST_PAYLOAD = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [7:0]       remain_ff, remain_in;
   logic [7:0]       csum_ff, csum_in;
   logic [AW-1:0]    wpos_ff, wpos_in;
   logic [7:0]       idle_cnt_ff, idle_cnt_in;
   logic             ovf_ff, ovf_in;
   logic [7:0]       reload_ff, reload_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [2:0]       hunt_state;

   assign hunt_state = (rx_byte == CHAR_U) ? ST_H1 : ST_HUNT;
   assign reload_in  = csr_we ? csr_wdata : reload_ff;

   always_comb begin
      state_in    = state_ff;
      remain_in   = remain_ff;
      csum_in     = csum_ff;
      wpos_in     = wpos_ff;
      idle_cnt_in = idle_cnt_ff;
      ovf_in      = ovf_ff;
      len_in      = len_ff;
      st_we       = 1'b0;
      st_waddr    = wpos_ff;
      st_wdata    = rx_byte;
      ev          = '0;
      if (take) begin
         if (req_type == REQ_TICK) begin
            if (idle_cnt_ff != 8'd0) begin
               idle_cnt_in = idle_cnt_ff - 8'd1;
               // abort the frame when the count runs out
               if (idle_cnt_ff == 8'd1) begin
                  state_in = ST_HUNT;
               end
            end
         end else begin
            idle_cnt_in = reload_ff;
            case (state_ff)
               ST_H1: begin
                  state_in = (rx_byte == CHAR_N) ? ST_H2 : hunt_state;
               end
               ST_H2: begin
                  state_in = (rx_byte == CHAR_E) ? ST_H3 : hunt_state;
               end
               ST_H3: begin
                  state_in = (rx_byte == CHAR_R) ? ST_LEN : hunt_state;
               end
               ST_LEN: begin
                  if (rx_byte == 8'd0) begin
                     state_in = ST_HUNT;
                  end else begin
                     remain_in = rx_byte;
                     state_in  = ST_TOKEN;
                  end
               end
               ST_TOKEN: begin
                  if (rx_byte == CHAR_COLON) begin
                     csum_in  = CSUM_SEED ^ remain_ff;
                     ovf_in   = (remain_ff > 8'(STORE_DEPTH));
                     len_in   = remain_ff[LEN_W-1:0];
                     st_we    = 1'b1;
                     st_waddr = '0;
                     st_wdata = remain_ff;
                     wpos_in  = AW'(1);
                     state_in = ST_PAYLOAD;
                  end else begin
                     state_in = hunt_state;
                  end
               end
               ST_PAYLOAD: begin
                  remain_in = remain_ff - 8'd1;
                  if (remain_ff > 8'd1) begin
                     // without overflow every position stays below the depth
                     if (!ovf_ff) begin
                        st_we   = 1'b1;
                        wpos_in = wpos_ff + AW'(1);
                     end
                     csum_in = csum_ff ^ rx_byte;
                  end else begin
                     state_in = ST_HUNT;
                     ev.valid = 1'b1;
                     ev.len   = len_ff;
                     ev.value = csum_ff;
                     ev.rchk  = rx_byte;
                     if (ovf_ff) begin
                        ev.kind = KIND_OVERFLOW;
                     end else if (csum_ff == rx_byte) begin
                        ev.kind = KIND_FRAME;
                     end else begin
                        ev.kind = KIND_ERROR;
                     end
                  end
               end
               default: begin
                  state_in = hunt_state;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_HUNT;
         remain_ff   <= '0;
         csum_ff     <= '0;
         wpos_ff     <= '0;
         idle_cnt_ff <= '0;
         ovf_ff      <= 1'b0;
         reload_ff   <= TIMEOUT_RESET;
      end else begin
         state_ff    <= state_in;
         remain_ff   <= remain_in;
         csum_ff     <= csum_in;
         wpos_ff     <= wpos_in;
         idle_cnt_ff <= idle_cnt_in;
         ovf_ff      <= ovf_in;
         reload_ff   <= reload_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
   end

endmodule

`default_nettype wire

@@ sv/fprc_drain.sv @@
`default_nettype none

module fprc_drain #(
   parameter int AW = 6
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire fprc_pkg::fprc_event_type ev,
   output logic                         busy,
   output logic                         st_re,
   output logic [AW-1:0]                st_raddr,
   input  wire logic [7:0]              st_rdata,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output logic [1:0]                   out_kind,
   output logic [5:0]                   out_index,
   output logic [7:0]                   out_value,
   output logic [7:0]                   out_rchk,
   output logic                         out_last
);
   import fprc_pkg::*;

   fprc_event_type   ev_ff, ev_in;
   logic [LEN_W-1:0] cnt_ff, cnt_in;
   logic [5:0]       rd_idx_ff, rd_idx_in;
   logic             pend_ff, pend_in;
   logic [5:0]       pend_idx_ff, pend_idx_in;
   logic             pend_last_ff, pend_last_in;
   logic             valid_ff, valid_in;
   logic [1:0]       kind_ff, kind_in;
   logic [5:0]       idx_ff, idx_in;
   logic [7:0]       val_ff, val_in;
   logic [7:0]       rchk_ff, rchk_in;
   logic             last_ff, last_in;
   logic             out_free, load_pend, issue, load_single;

   assign out_free    = !valid_ff || out_ready;
   assign load_pend   = pend_ff && out_free;
   assign issue       = (cnt_ff != '0) && (!pend_ff || load_pend);
   assign load_single = ev_ff.valid && (ev_ff.kind != KIND_FRAME) && out_free;
   assign busy        = ev_ff.valid || (cnt_ff != '0) || pend_ff;
   assign st_re       = issue;
   assign st_raddr    = rd_idx_ff[AW-1:0];

   always_comb begin
      ev_in        = ev_ff;
      cnt_in       = cnt_ff;
      rd_idx_in    = rd_idx_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      pend_last_in = pend_last_ff;
      valid_in     = valid_ff;
      kind_in      = kind_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      rchk_in      = rchk_ff;
      last_in      = last_ff;

      if (ev.valid) begin
         ev_in = ev;
      end else if (ev_ff.valid && ev_ff.kind == KIND_FRAME) begin
         // start the readout from the length entry
         ev_in.valid = 1'b0;
         cnt_in      = ev_ff.len;
         rd_idx_in   = '0;
      end else if (load_single) begin
         ev_in.valid = 1'b0;
      end

      if (issue) begin
         cnt_in       = cnt_ff - LEN_W'(1);
         rd_idx_in    = rd_idx_ff + 6'd1;
         pend_in      = 1'b1;
         pend_idx_in  = rd_idx_ff;
         pend_last_in = (cnt_ff == LEN_W'(1));
      end else if (load_pend) begin
         pend_in = 1'b0;
      end

      if (load_pend) begin
         valid_in = 1'b1;
         kind_in  = KIND_FRAME;
         idx_in   = pend_idx_ff;
         val_in   = st_rdata;
         rchk_in  = 8'd0;
         last_in  = pend_last_ff;
      end else if (load_single) begin
         valid_in = 1'b1;
         kind_in  = ev_ff.kind;
         idx_in   = 6'd0;
         val_in   = ev_ff.value;
         rchk_in  = ev_ff.rchk;
         last_in  = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_ff.valid <= 1'b0;
         cnt_ff      <= '0;
         pend_ff     <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         ev_ff.valid <= ev_in.valid;
         cnt_ff      <= cnt_in;
         pend_ff     <= pend_in;
         valid_ff    <= valid_in;
      end
      ev_ff.kind   <= ev_in.kind;
      ev_ff.len    <= ev_in.len;
      ev_ff.value  <= ev_in.value;
      ev_ff.rchk   <= ev_in.rchk;
      rd_idx_ff    <= rd_idx_in;
      pend_idx_ff  <= pend_idx_in;
      pend_last_ff <= pend_last_in;
      kind_ff      <= kind_in;
      idx_ff       <= idx_in;
      val_ff       <= val_in;
      rchk_ff      <= rchk_in;
      last_ff      <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_kind  = kind_ff;
   assign out_index = idx_ff;
   assign out_value = val_ff;
   assign out_rchk  = rchk_ff;
   assign out_last  = last_ff;

endmodule

`default_nettype wire

@@ sv/framed_packet_receiver_core.sv @@
// Channel   Dir  tdata                                  tuser     tlast
// req       in   rx_byte[7:0]                           req_type  -
// rsp       out  index[5:0] value[13:6] rchk[21:14]     kind      last
// csr       in   timeout_reload (write only)            -         -
//
// Header, length, token and payload bytes and ticks are taken one per cycle.
// A good frame of length L is read out of the frame store at one item per
// cycle; req_tready stays low until the last read has left the store port.
// An error or overflow frame gives a single item. Synchronous reset returns the
// parser to the header hunt; the store is not cleared. rsp_tready low holds
// the output register and the readout.
`default_nettype none
`include "framed_packet_receiver_core_macros.svh"

module framed_packet_receiver_core #(
   parameter int STORE_DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // rx_byte[7:0]
   input  wire logic        req_tuser,   // req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // index[5:0], value[13:6], received_checksum[21:14]
   output logic [1:0]       rsp_tuser,   // kind[1:0]
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [7:0]  csr_wdata
);
   import fprc_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);

   fprc_event_type ev;
   logic           take, drain_busy;
   logic           st_we, st_re;
   logic [AW-1:0]  st_waddr, st_raddr;
   logic [7:0]     st_wdata, st_rdata;
   logic [5:0]     out_index;
   logic [7:0]     out_value, out_rchk;

   // hold input off while the store is being read out or an item waits
   assign req_tready = !drain_busy;
   assign take       = req_tvalid && req_tready;

   fprc_parser #(.STORE_DEPTH(STORE_DEPTH), .AW(AW)) u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .req_type  (req_tuser),
      .rx_byte   (req_tdata),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .st_we     (st_we),
      .st_waddr  (st_waddr),
      .st_wdata  (st_wdata),
      .ev        (ev)
   );

   fprc_store #(.STORE_DEPTH(STORE_DEPTH), .AW(AW)) u_store (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .re    (st_re),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

   fprc_drain #(.AW(AW)) u_drain (
      .clock     (clock),
      .reset     (reset),
      .ev        (ev),
      .busy      (drain_busy),
      .st_re     (st_re),
      .st_raddr  (st_raddr),
      .st_rdata  (st_rdata),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_kind  (rsp_tuser),
      .out_index (out_index),
      .out_value (out_value),
      .out_rchk  (out_rchk),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, out_rchk, out_value, out_index};

   `FPRC_ASSERT_NOW(a_no_write_in_readout, clock, reset, st_we, !drain_busy, "store written during readout")
   `FPRC_ASSERT_NOW(a_write_from_item, clock, reset, st_we, take && req_tuser == REQ_BYTE, "store write without a byte")
   `FPRC_ASSERT_NOW(a_single_item, clock, reset, rsp_tvalid && rsp_tuser != KIND_FRAME, rsp_tlast && out_index == 6'd0, "bad error item")

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fprc_pkg::*;

   localparam int STORE_DEPTH  = 64;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 12;

   typedef struct packed {
      logic       is_tick;
      logic [7:0] data;
   } rx_item_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [5:0] index;
      logic [7:0] value;
      logic [7:0] rchk;
      logic       last;
   } frame_result_type;

   typedef enum logic [2:0] {
      PS_HUNT, PS_H1, PS_H2, PS_H3, PS_LEN, PS_TOKEN, PS_PAYLOAD
   } parse_state_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tuser  = REQ_BYTE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic [7:0]  csr_wdata  = 8'h00;

   framed_packet_receiver_core #(.STORE_DEPTH(STORE_DEPTH)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Stimulus side
   rx_item_type      rx_stream[$];
   int               in_flight     = 0;
   int               phase_items   = 0;
   logic [7:0]       phase_reload  = TIMEOUT_RESET;
   bit               no_idle       = 1'b0;

   // Receiver shadow state
   logic [7:0]       cfg_reload    = TIMEOUT_RESET;
   parse_state_type  pstate        = PS_HUNT;
   logic [7:0]       remaining     = 8'h00;
   logic [7:0]       csum          = 8'h00;
   int               wpos          = 0;
   logic [7:0]       store[STORE_DEPTH];
   logic [7:0]       idle_count    = 8'h00;
   bit               ovf           = 1'b0;
   frame_result_type frame_results_due[$];

   // Bookkeeping
   bit               req_fire      = 1'b0;
   int               fail_count    = 0;
   int               items_taken   = 0;
   int               results_seen  = 0;
   int               n_good        = 0;
   int               n_csum_err    = 0;
   int               n_ovf         = 0;
   int               n_timeouts    = 0;
   int               stall_cycles  = 0;

   function automatic parse_state_type hunt_next(logic [7:0] b);
      return (b == CHAR_U) ? PS_H1 : PS_HUNT;
   endfunction

   function automatic void push_result(logic [1:0] kind, logic [5:0] idx, logic [7:0] val,
                                       logic [7:0] rchk, logic last);
      frame_result_type r;
      r.kind  = kind;
      r.index = idx;
      r.value = val;
      r.rchk  = rchk;
      r.last  = last;
      frame_results_due.push_back(r);
   endfunction

   function automatic void predict_item(logic tuser, logic [7:0] b);
      int len;
      if (tuser == REQ_TICK) begin
         if (idle_count != 8'd0) begin
            idle_count = idle_count - 8'd1;
            if (idle_count == 8'd0) begin
               if (pstate != PS_HUNT) n_timeouts++;
               pstate = PS_HUNT;
            end
         end
         return;
      end
      idle_count = cfg_reload;
      case (pstate)
         PS_H1: pstate = (b == CHAR_N) ? PS_H2 : hunt_next(b);
         PS_H2: pstate = (b == CHAR_E) ? PS_H3 : hunt_next(b);
         PS_H3: pstate = (b == CHAR_R) ? PS_LEN : hunt_next(b);
         PS_LEN: begin
            if (b == 8'h00) begin
               pstate = PS_HUNT;
            end else begin
               remaining = b;
               pstate    = PS_TOKEN;
            end
         end
         PS_TOKEN: begin
            if (b == CHAR_COLON) begin
               csum     = CSUM_SEED ^ remaining;
               ovf      = (remaining > STORE_DEPTH);
               store[0] = remaining;
               wpos     = 1;
               pstate   = PS_PAYLOAD;
            end else begin
               pstate = hunt_next(b);
            end
         end
         PS_PAYLOAD: begin
            if (remaining > 8'd1) begin
               if (!ovf && wpos < STORE_DEPTH) begin
                  store[wpos] = b;
                  wpos++;
               end
               csum ^= b;
            end
            remaining = remaining - 8'd1;
            if (remaining == 8'd0) begin
               pstate = PS_HUNT;
               if (ovf) begin
                  push_result(KIND_OVERFLOW, 6'd0, csum, b, 1'b1);
                  n_ovf++;
               end else if (csum == b) begin
                  len = int'(store[0]);
                  for (int k = 0; k < len; k++)
                     push_result(KIND_FRAME, 6'(k), store[k], 8'h00, k == len - 1);
                  n_good++;
               end else begin
                  push_result(KIND_ERROR, 6'd0, csum, b, 1'b1);
                  n_csum_err++;
               end
            end
         end
         default: pstate = hunt_next(b);
      endcase
   endfunction

   function automatic void flag_mismatch(string what, frame_result_type want,
                                         frame_result_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t ns %s: expected kind %0d index %0d value %02h rchk %02h last %0b, %s",
                  $realtime, what, want.kind, want.index, want.value, want.rchk, want.last,
                  $sformatf("got kind %0d index %0d value %02h rchk %02h last %0b",
                            got.kind, got.index, got.value, got.rchk, got.last));
   endfunction

   // Sample both channels and the register write at the rising edge
   always @(posedge clock) begin : monitor
      frame_result_type got;
      frame_result_type want;
      req_fire = req_tvalid && req_tready && !reset;
      if (!reset) begin
         if (csr_we)
            cfg_reload = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            got.kind  = rsp_tuser;
            got.index = rsp_tdata[5:0];
            got.value = rsp_tdata[13:6];
            got.rchk  = rsp_tdata[21:14];
            got.last  = rsp_tlast;
            results_seen++;
            if (frame_results_due.size() == 0) begin
               flag_mismatch("unexpected result", '0, got);
            end else begin
               want = frame_results_due.pop_front();
               if (got !== want || rsp_tdata[23:22] !== 2'b00)
                  flag_mismatch("result mismatch", want, got);
            end
         end
         if (req_fire) begin
            in_flight--;
            items_taken++;
            predict_item(req_tuser, req_tdata);
         end
      end
   end

   // Item driver: hold until taken, then idle in bursts or present the next item
   int req_gap_left = 0;
   int req_calm     = 0;

   always @(negedge clock) begin : req_driver
      rx_item_type next_item;
      if (!reset && !(req_tvalid && !req_fire)) begin
         if (req_gap_left > 0) begin
            req_gap_left--;
            req_tvalid <= 1'b0;
         end else if (!no_idle && req_calm == 0 && $urandom_range(0, 7) == 0) begin
            req_gap_left = $urandom_range(0, 10);
            req_calm     = $urandom_range(0, 40);
            req_tvalid   <= 1'b0;
         end else if (rx_stream.size() != 0) begin
            next_item  = rx_stream.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= next_item.is_tick;
            req_tdata  <= next_item.data;
            if (req_calm > 0) req_calm--;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   int rsp_hold_left = 0;
   int rsp_calm      = 0;

   always @(negedge clock) begin : rsp_driver
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else if (!no_idle && rsp_calm == 0 && $urandom_range(0, 5) == 0) begin
         rsp_hold_left = $urandom_range(0, 10);
         rsp_calm      = $urandom_range(0, 30);
         rsp_tready    <= 1'b0;
      end else begin
         if (rsp_calm > 0) rsp_calm--;
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles == STALL_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic push_byte(logic [7:0] b);
      rx_stream.push_back({REQ_BYTE, b});
      in_flight++;
      phase_items++;
   endtask

   task automatic push_tick();
      rx_stream.push_back({REQ_TICK, 8'($urandom_range(0, 255))});
      in_flight++;
      phase_items++;
   endtask

   task automatic push_header(int len);
      push_byte(CHAR_U);
      push_byte(CHAR_N);
      push_byte(CHAR_E);
      push_byte(CHAR_R);
      push_byte(8'(len));
   endtask

   task automatic push_frame(int len, bit bad, bit with_ticks);
      logic [7:0] sum;
      logic [7:0] b;
      sum = CSUM_SEED ^ 8'(len);
      push_header(len);
      push_byte(CHAR_COLON);
      for (int i = 1; i < len; i++) begin
         b = 8'($urandom_range(0, 255));
         sum ^= b;
         push_byte(b);
         if (with_ticks && $urandom_range(0, 3) == 0) push_tick();
      end
      if (bad) sum ^= 8'($urandom_range(1, 255));
      push_byte(sum);
   endtask

   // Start a frame, stop partway, then tick; the ticks time out the frame only for a reload of 1 to 16
   task automatic push_truncated();
      int len;
      len = $urandom_range(3, 20);
      push_header(len);
      push_byte(CHAR_COLON);
      repeat ($urandom_range(0, len - 2)) push_byte(8'($urandom_range(0, 255)));
      repeat ((phase_reload != 0 && phase_reload <= 16) ? phase_reload : 3) push_tick();
   endtask

   task automatic push_broken_header();
      logic [7:0] seq[6];
      int         k;
      seq = '{CHAR_U, CHAR_N, CHAR_E, CHAR_R, 8'($urandom_range(1, 20)), CHAR_COLON};
      k   = $urandom_range(1, 5);
      for (int i = 0; i < k; i++) push_byte(seq[i]);
      push_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic random_traffic(int n);
      int pick;
      int len;
      phase_items = 0;
      while (phase_items < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
            if ($urandom_range(0, 24) == 0) len = $urandom_range(65, 80);
            push_frame(len, $urandom_range(0, 4) == 0, $urandom_range(0, 2) == 0);
         end else if (pick < 70) begin
            push_truncated();
         end else if (pick < 80) begin
            push_broken_header();
         end else if (pick < 92) begin
            repeat ($urandom_range(1, 5)) push_byte(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 4)) push_tick();
         end
      end
   endtask

   // Drain everything, then give the readout time to settle
   task automatic wait_quiet();
      while (in_flight != 0 || frame_results_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reload(logic [7:0] v);
      phase_reload = v;
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin : stimulus
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // tick with the inactivity counter already at zero
      push_tick();
      // broken header restarts on U, then a zero length drops the frame
      push_byte(CHAR_U);
      push_byte(CHAR_N);
      push_header(0);
      // bad token that is itself a U, then a one-byte frame
      push_header(1);
      push_frame(1, 1'b0, 1'b0);
      push_frame(2, 1'b1, 1'b0);
      random_traffic(25);
      wait_quiet();

      write_reload(8'd0);
      random_traffic(20);
      wait_quiet();

      write_reload(8'd255);
      push_frame(STORE_DEPTH, 1'b0, 1'b0);
      push_frame(80, 1'b0, 1'b1);
      random_traffic(15);
      wait_quiet();

      write_reload(8'd1);
      random_traffic(20);
      wait_quiet();

      no_idle = 1'b1;
      write_reload(8'($urandom_range(2, 12)));
      random_traffic(20);
      wait_quiet();

      $display("Covered %0d items and %0d results: %0d good frames, %0d checksum errors,",
               items_taken, results_seen, n_good, n_csum_err);
      $display("%0d overflows, %0d timeouts; timeout reloads 6, 0, 255, 1 and %0d.",
               n_ovf, n_timeouts, phase_reload);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
